>>> hw/rtl/bus_state_controller_regs_core_defines.svh
// Assertion macros shared by the bus state controller register block.
// Included by the top-level core, which carries the concurrent checks; no other dependencies.
`ifndef BUS_STATE_CONTROLLER_REGS_CORE_DEFINES_SVH
`define BUS_STATE_CONTROLLER_REGS_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property under reset disable.
`define BSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property that must also hold while reset is high.
`define BSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSC_ASSERT(lbl, clk, rst, prop, msg)
`define BSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hw/rtl/bsc_pkg.sv
// Shared types, register offsets, masks and reset values for the bus state
// controller register block. No dependencies.
package bsc_pkg;

  localparam int unsigned OFFSET_W = 7;
  localparam int unsigned DATA_W   = 32;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [OFFSET_W-1:0] OFF_BCR1       = 7'h00;
  localparam logic [OFFSET_W-1:0] OFF_BCR1_HI    = 7'h02;
  localparam logic [OFFSET_W-1:0] OFF_BCR2       = 7'h04;
  localparam logic [OFFSET_W-1:0] OFF_BCR2_ALIAS = 7'h06;
  localparam logic [OFFSET_W-1:0] OFF_WCR1       = 7'h08;
  localparam logic [OFFSET_W-1:0] OFF_WCR2       = 7'h0C;
  localparam logic [OFFSET_W-1:0] OFF_WCR3       = 7'h10;
  localparam logic [OFFSET_W-1:0] OFF_MCR        = 7'h14;
  localparam logic [OFFSET_W-1:0] OFF_PCR        = 7'h18;
  localparam logic [OFFSET_W-1:0] OFF_RTCSR      = 7'h1C;
  localparam logic [OFFSET_W-1:0] OFF_RTCNT      = 7'h20;
  localparam logic [OFFSET_W-1:0] OFF_RTCOR      = 7'h24;
  localparam logic [OFFSET_W-1:0] OFF_RFCR       = 7'h28;
  localparam logic [OFFSET_W-1:0] OFF_PCTRA      = 7'h2C;
  localparam logic [OFFSET_W-1:0] OFF_PDTRA      = 7'h30;
  localparam logic [OFFSET_W-1:0] OFF_PCTRB      = 7'h40;
  localparam logic [OFFSET_W-1:0] OFF_PDTRB      = 7'h44;
  localparam logic [OFFSET_W-1:0] OFF_GPIOIC     = 7'h48;

  localparam logic [31:0] MASK_BCR1  = 32'h033E_FFFD;
  localparam logic [15:0] MASK_BCR2  = 16'h3FFD;
  localparam logic [31:0] MASK_WCR1  = 32'h7777_7777;
  localparam logic [31:0] MASK_WCR2  = 32'hFFFE_EFFF;
  localparam logic [31:0] MASK_WCR3  = 32'h0777_7777;
  localparam logic [31:0] MASK_MCR   = 32'hF8BB_FFFF;
  localparam logic [3:0]  MASK_PDTRB = 4'hF;

  localparam logic [15:0] RESET_BCR2 = 16'h3FFC;
  localparam logic [31:0] RESET_WCR1 = 32'h7777_7777;
  localparam logic [31:0] RESET_WCR2 = 32'hFFFE_EFFF;
  localparam logic [31:0] RESET_WCR3 = 32'h0777_7777;

  localparam logic [7:0]        RTCSR_READ_SET = 8'hC0;
  localparam logic [DATA_W-1:0] RFCR_VALUE     = 32'd17;

  typedef struct packed {
    logic                en;
    logic                wr;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   wdata;
  } bsc_access_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              bad_offset;
  } bsc_result_t;

  // Port A data as seen by software: pull-up pattern in bits 1:0 from the control
  // and data nibbles, cable type in bits 9:8.
  function automatic logic [DATA_W-1:0] port_a_read(input logic [3:0] c,
                                                    input logic [3:0] d,
                                                    input logic [1:0] cable);
    logic [1:0] low;
    low = (c == 4'h8 || c == 4'hB) ? 2'd3 : 2'd0;
    if (c == 4'hB && d == 4'h2) begin
      low = 2'd0;
    end else if (c == 4'hC && d == 4'h2) begin
      low = 2'd3;
    end
    return {22'd0, cable, 6'd0, low};
  endfunction

endpackage

>>> hw/rtl/bsc_if.sv
// Valid/ready channel interfaces for the bus state controller register block.
// Depends on bsc_pkg.
interface bsc_req_if import bsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [OFFSET_W-1:0] offset;
  logic [DATA_W-1:0]   write_data;
  modport source (output valid, cmd, offset, write_data, input ready);
  modport sink (input valid, cmd, offset, write_data, output ready);
endinterface

interface bsc_rsp_if import bsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              bad_offset;
  modport source (output valid, read_data, bad_offset, input ready);
  modport sink (input valid, read_data, bad_offset, output ready);
endinterface

interface bsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] video_cable;
  modport source (output valid, video_cable, input ready);
  modport sink (input valid, video_cable, output ready);
endinterface

>>> hw/rtl/bus_state_controller_regs_core.sv
// Top level of the bus state controller register block: input register,
// register bank and result register. Depends on bsc_pkg, bsc_if, bsc_regfile.
//
// Usage:
//   req  - access transactions (cmd: read or write, byte offset, write_data).
//   rsp  - one result per access: read_data (zero for writes) and bad_offset.
//   cfg  - write-only channel for the video cable type; always ready. Write it
//          only while no access is in flight.
// Timing:
//   An accepted access is held in the input register, decoded from it, and its
//   result is captured in the output register, which drives rsp.valid. One
//   access per cycle is sustained while rsp.ready stays high; the register bank
//   is read and written in the same decode cycle.
// Reset (rst, synchronous): both pipeline stages empty, all bank registers return
//   to their reset values, video cable type 0.
// Stall: while rsp.ready is low the result holds; the input register still
//   takes one more transaction, then req.ready drops until rsp drains.
`include "bus_state_controller_regs_core_defines.svh"
module bus_state_controller_regs_core import bsc_pkg::*; (
  input logic      clk,
  input logic      rst,
  bsc_req_if.sink  req,
  bsc_rsp_if.source rsp,
  bsc_cfg_if.sink  cfg
);

  logic                s1_valid;
  logic                s1_wr;
  logic [OFFSET_W-1:0] s1_offset;
  logic [DATA_W-1:0]   s1_wdata;
  logic                s1_advance;
  logic                out_valid;
  bsc_result_t         out_result;
  bsc_access_t         acc;
  bsc_result_t         result;

  assign s1_advance = s1_valid && (!out_valid || rsp.ready);
  assign req.ready  = !s1_valid || s1_advance;
  assign cfg.ready  = 1'b1;

  assign acc.en     = s1_advance;
  assign acc.wr     = s1_wr;
  assign acc.offset = s1_offset;
  assign acc.wdata  = s1_wdata;

  bsc_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .cfg_we    (cfg.valid),
    .cfg_cable (cfg.video_cable),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (!out_valid || rsp.ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_wr     <= (req.cmd == CMD_WRITE);
      s1_offset <= req.offset;
      s1_wdata  <= req.write_data;
    end
    if (s1_advance) begin
      out_result <= result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_result.read_data;
  assign rsp.bad_offset = out_result.bad_offset;

  `BSC_ASSERT(a_rfcr_reads_fixed, clk, rst,
    s1_advance && !s1_wr && s1_offset == OFF_RFCR |=> rsp.valid && rsp.read_data == RFCR_VALUE,
    "read-only count register returned a wrong value")
  `BSC_ASSERT(a_write_returns_zero, clk, rst,
    s1_advance && s1_wr |=> rsp.valid && rsp.read_data == '0,
    "write transaction returned non-zero data")
  `BSC_ASSERT(a_bad_offset_no_data, clk, rst,
    rsp.valid && rsp.bad_offset |-> rsp.read_data == '0,
    "unmapped offset returned data")
  `BSC_ASSERT_ALWAYS(a_empty_after_reset, clk,
    $past(rst) |-> !rsp.valid && !s1_valid,
    "pipeline not empty after reset")

endmodule

>>> hw/rtl/bsc_regfile.sv
// Register bank of the bus state controller: masked writes, read decode.
// Depends on bsc_pkg.
module bsc_regfile import bsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bsc_access_t acc,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_cable,
  output bsc_result_t result
);

  logic [31:0] bcr1;
  logic [15:0] bcr2;
  logic [31:0] wcr1;
  logic [31:0] wcr2;
  logic [31:0] wcr3;
  logic [31:0] mcr;
  logic [15:0] pcr;
  logic [7:0]  rtcsr;
  logic [7:0]  rtcnt;
  logic [7:0]  rtcor;
  logic [31:0] pctra;
  logic [15:0] pdtra;
  logic [7:0]  pctrb;
  logic [3:0]  pdtrb;
  logic [15:0] gpioic;
  logic [1:0]  video_cable;

  always_ff @(posedge clk) begin
    if (rst) begin
      bcr1        <= '0;
      bcr2        <= RESET_BCR2;
      wcr1        <= RESET_WCR1;
      wcr2        <= RESET_WCR2;
      wcr3        <= RESET_WCR3;
      mcr         <= '0;
      pcr         <= '0;
      rtcsr       <= '0;
      rtcnt       <= '0;
      rtcor       <= '0;
      pctra       <= '0;
      pdtra       <= '0;
      pctrb       <= '0;
      pdtrb       <= '0;
      gpioic      <= '0;
      video_cable <= '0;
    end else begin
      if (cfg_we) begin
        video_cable <= cfg_cable;
      end
      if (acc.en && acc.wr) begin
        case (acc.offset)
          OFF_BCR1:                 bcr1   <= acc.wdata & MASK_BCR1;
          // upper half-word alias replaces bits 31:16 unmasked
          OFF_BCR1_HI:              bcr1   <= {acc.wdata[15:0], bcr1[15:0]};
          OFF_BCR2, OFF_BCR2_ALIAS: bcr2   <= acc.wdata[15:0] & MASK_BCR2;
          OFF_WCR1:                 wcr1   <= acc.wdata & MASK_WCR1;
          OFF_WCR2:                 wcr2   <= acc.wdata & MASK_WCR2;
          OFF_WCR3:                 wcr3   <= acc.wdata & MASK_WCR3;
          OFF_MCR:                  mcr    <= acc.wdata & MASK_MCR;
          OFF_PCR:                  pcr    <= acc.wdata[15:0];
          OFF_RTCSR:                rtcsr  <= acc.wdata[7:0];
          OFF_RTCNT:                rtcnt  <= acc.wdata[7:0];
          OFF_RTCOR:                rtcor  <= acc.wdata[7:0];
          OFF_PCTRA:                pctra  <= acc.wdata;
          OFF_PDTRA:                pdtra  <= acc.wdata[15:0];
          OFF_PCTRB:                pctrb  <= acc.wdata[7:0];
          OFF_PDTRB:                pdtrb  <= acc.wdata[3:0] & MASK_PDTRB;
          OFF_GPIOIC:               gpioic <= acc.wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    result = '0;
    case (acc.offset)
      OFF_BCR1:                 result.read_data = bcr1;
      OFF_BCR1_HI:              result.read_data = {16'd0, bcr1[31:16]};
      OFF_BCR2, OFF_BCR2_ALIAS: result.read_data = {16'd0, bcr2};
      OFF_WCR1:                 result.read_data = wcr1;
      OFF_WCR2:                 result.read_data = wcr2;
      OFF_WCR3:                 result.read_data = wcr3;
      OFF_MCR:                  result.read_data = mcr;
      OFF_PCR:                  result.read_data = {16'd0, pcr};
      OFF_RTCSR:                result.read_data = {24'd0, rtcsr | RTCSR_READ_SET};
      OFF_RTCNT:                result.read_data = {24'd0, rtcnt};
      OFF_RTCOR:                result.read_data = {24'd0, rtcor};
      OFF_RFCR:                 result.read_data = RFCR_VALUE;
      OFF_PCTRA:                result.read_data = pctra;
      OFF_PDTRA:                result.read_data = port_a_read(pctra[3:0], pdtra[3:0],
                                                               video_cable);
      OFF_PCTRB:                result.read_data = {24'd0, pctrb};
      OFF_PDTRB:                result.read_data = {28'd0, pdtrb};
      OFF_GPIOIC:               result.read_data = {16'd0, gpioic};
      default:                  result.bad_offset = 1'b1;
    endcase
    // writes return no data
    if (acc.wr) begin
      result.read_data = '0;
    end
  end

endmodule
